[rtl/core/rsp_pkg.sv]
`timescale 1ns / 1ps

package rsp_pkg;

  localparam logic [7:0] PROD_FULL    = 8'h22;
  localparam logic [7:0] PROD_REDUCED = 8'h20;

  localparam logic [3:0] LAST_TARGET = 4'd8;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_TOO_LOW     = 3'd1;
  localparam logic [2:0] ST_TOO_HIGH    = 3'd2;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
  localparam logic [2:0] ST_BAD_PRODUCT = 3'd4;

  localparam logic [11:0] BUCK_BASE_MV = 12'd500;
  localparam logic [11:0] LDO_BASE_MV  = 12'd900;
  localparam logic [11:0] LDO4_MV      = 12'd3300;

  // floor(x/10) = (x*205)>>11 for x < 1029
  localparam logic [7:0] DIV10_MUL   = 8'd205;
  localparam int         DIV10_SHIFT = 11;
  // floor(y/100) = (y*1311)>>17 for y <= 2400
  localparam logic [10:0] DIV100_MUL   = 11'd1311;
  localparam int          DIV100_SHIFT = 17;

  localparam logic [0:0] ADDR_EMULATED = 1'b0;
  localparam logic [0:0] ADDR_PRODUCT  = 1'b1;

  typedef struct packed {
    logic        is_buck;
    logic        is_ldo4;
    logic [7:0]  reg_addr;
    logic [11:0] min_mv;
    logic [11:0] max_mv;
    logic        in_reduced;
  } rail_t;

  function automatic rail_t rail_lookup(input logic [3:0] target);
    rail_t r;
    case (target)
      4'd0:    r = '{1'b1, 1'b0, 8'h25, 12'd670,  12'd842,  1'b1};
      4'd1:    r = '{1'b1, 1'b0, 8'h20, 12'd640,  12'd935,  1'b1};
      4'd2:    r = '{1'b1, 1'b0, 8'h2a, 12'd760,  12'd961,  1'b1};
      4'd3:    r = '{1'b0, 1'b0, 8'h5e, 12'd1800, 12'd3300, 1'b1};
      4'd4:    r = '{1'b0, 1'b0, 8'h61, 12'd1800, 12'd3300, 1'b1};
      4'd5:    r = '{1'b0, 1'b0, 8'h58, 12'd1800, 12'd3300, 1'b0};
      4'd6:    r = '{1'b0, 1'b0, 8'h4f, 12'd1200, 12'd3300, 1'b0};
      4'd7:    r = '{1'b0, 1'b0, 8'h5b, 12'd1200, 12'd3300, 1'b0};
      4'd8:    r = '{1'b0, 1'b1, 8'h55, 12'd3300, 12'd3300, 1'b1};
      default: r = '{1'b0, 1'b0, 8'h00, 12'd0,    12'd0,    1'b0};
    endcase
    return r;
  endfunction

endpackage

[rtl/core/regulator_setpoint_programmer.sv]
`timescale 1ns / 1ps

// channel  | ports                                         | handshake
// request  | target, request_mv                            | start & !busy
// result   | write_valid, reg_addr, reg_data, status,      | done, one cycle
//          | applied_mv, last                              |
// config   | psel, penable, pwrite, paddr, pwdata, prdata  | APB, pready = 1
//
// An item is captured in the input register; its result is computed from it
// combinationally and registered onto the outputs. Buck items hold the input
// register for both writes (busy blocks start between them); others give one.
// rst is synchronous: clears in_valid, phase and done and restores the config registers.
// The result side cannot stall; busy only covers the second buck write.

module regulator_setpoint_programmer (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  target,
  input  logic [11:0] request_mv,
  output logic        done,
  output logic        write_valid,
  output logic [7:0]  reg_addr,
  output logic [7:0]  reg_data,
  output logic [2:0]  status,
  output logic [11:0] applied_mv,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        emulated_board;
  logic [7:0]  product_id;

  logic        in_valid;
  logic        phase;
  logic [3:0]  in_target;
  logic [11:0] in_mv;

  rsp_pkg::rail_t rail;
  logic        two_results;
  logic        r_wv;
  logic [7:0]  r_addr;
  logic [7:0]  r_data;
  logic [2:0]  r_status;
  logic [11:0] r_mv;
  logic        r_last;

  logic        en;
  logic [8:0]  buck_x;
  logic [16:0] buck_prod;
  logic [5:0]  buck_code;
  logic [11:0] ldo_y;
  logic [22:0] ldo_prod;
  logic [4:0]  ldo_code;
  logic [11:0] buck_back;
  logic [11:0] ldo_back;

  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      rsp_pkg::ADDR_EMULATED: prdata = {31'd0, emulated_board};
      rsp_pkg::ADDR_PRODUCT:  prdata = {24'd0, product_id};
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emulated_board <= 1'b0;
      product_id     <= rsp_pkg::PROD_FULL;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        rsp_pkg::ADDR_EMULATED: emulated_board <= pwdata[0];
        rsp_pkg::ADDR_PRODUCT:  product_id     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // item compute
  always_comb begin
    rail      = rsp_pkg::rail_lookup(in_target);
    en        = (in_mv != 12'd0);
    buck_x    = 9'(in_mv - rsp_pkg::BUCK_BASE_MV);
    buck_prod = 17'(buck_x) * 17'(rsp_pkg::DIV10_MUL);
    buck_code = en ? 6'(buck_prod >> rsp_pkg::DIV10_SHIFT) : 6'd0;
    ldo_y     = in_mv - rsp_pkg::LDO_BASE_MV;
    ldo_prod  = 23'(ldo_y) * 23'(rsp_pkg::DIV100_MUL);
    ldo_code  = en ? 5'(ldo_prod >> rsp_pkg::DIV100_SHIFT) : 5'd0;
    buck_back = en ? 12'(rsp_pkg::BUCK_BASE_MV + 12'(buck_code) * 12'd10) : 12'd0;
    ldo_back  = en ? 12'(rsp_pkg::LDO_BASE_MV + 12'(ldo_code) * 12'd100) : 12'd0;

    two_results = 1'b0;
    r_wv     = 1'b0;
    r_addr   = 8'd0;
    r_data   = 8'd0;
    r_status = rsp_pkg::ST_OK;
    r_mv     = 12'd0;
    r_last   = 1'b1;

    if (emulated_board) begin
      r_mv = in_mv;
    end else if (product_id != rsp_pkg::PROD_FULL &&
                 product_id != rsp_pkg::PROD_REDUCED) begin
      r_status = rsp_pkg::ST_BAD_PRODUCT;
    end else if (in_target > rsp_pkg::LAST_TARGET ||
                 (product_id == rsp_pkg::PROD_REDUCED && !rail.in_reduced)) begin
      r_status = rsp_pkg::ST_UNSUPPORTED;
    end else if (en && in_mv < rail.min_mv) begin
      r_status = rsp_pkg::ST_TOO_LOW;
    end else if (in_mv > rail.max_mv) begin
      r_status = rsp_pkg::ST_TOO_HIGH;
    end else if (rail.is_buck) begin
      two_results = 1'b1;
      r_wv = 1'b1;
      if (!phase) begin
        r_addr = rail.reg_addr;
        r_data = {2'd0, buck_code};
        r_last = 1'b0;
      end else begin
        r_addr = rail.reg_addr + 8'd1;
        r_data = {7'd0, en};
        r_mv   = buck_back;
      end
    end else begin
      r_wv   = 1'b1;
      r_addr = rail.reg_addr;
      if (rail.is_ldo4) begin
        r_data = {7'd0, en};
        r_mv   = en ? rsp_pkg::LDO4_MV : 12'd0;
      end else begin
        r_data = {2'd0, ldo_code, en};
        r_mv   = ldo_back;
      end
    end
  end

  assign busy = in_valid && two_results && !phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      phase    <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= in_valid;
      if (busy) begin
        phase <= 1'b1;
      end else begin
        phase    <= 1'b0;
        in_valid <= start;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_target <= target;
      in_mv     <= request_mv;
    end
    write_valid <= r_wv;
    reg_addr    <= r_addr;
    reg_data    <= r_data;
    status      <= r_status;
    applied_mv  <= r_mv;
    last        <= r_last;
  end

endmodule
